FILE: rtl/bfl_pkg.sv
// Shared types, constants and register codes of the bitmap font text layout block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bfl_pkg;

	// String length limit and the width of the byte count that reaches it
	localparam int unsigned MAX_STRING_BYTES = 256;
	localparam int unsigned CNT_W            = $clog2(MAX_STRING_BYTES + 1);

	// Glyph command queue
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	// Atlas index of a printable byte is below 95
	localparam int unsigned IDX_W = 7;

	localparam logic [7:0]  NUL_BYTE      = 8'h00;
	localparam logic [7:0]  NL_BYTE       = 8'h0A;
	localparam logic [7:0]  SPACE_BYTE    = 8'h20;
	localparam logic [7:0]  GLYPH_FIRST   = 8'h21;
	localparam logic [7:0]  HIGH_FIRST    = 8'h80;
	localparam logic [7:0]  ESC_BYTE      = 8'h8A;
	localparam logic [7:0]  GLYPH_OFFSET  = 8'd33;
	localparam logic [7:0]  RESET_GRAY    = 8'd128;
	localparam logic [15:0] DRAW_Y_OFFSET = 16'd8;

	localparam logic [7:0] RST_GLYPH_WIDTH    = 8'd8;
	localparam logic [7:0] RST_GLYPH_HEIGHT   = 8'd8;
	localparam logic [7:0] RST_GLYPHS_PER_ROW = 8'd16;
	localparam logic [7:0] RST_ATLAS_BASE_U   = 8'd0;
	localparam logic [7:0] RST_ATLAS_BASE_V   = 8'd0;

	typedef enum logic [2:0] {
		REG_GLYPH_WIDTH    = 3'd0,
		REG_GLYPH_HEIGHT   = 3'd1,
		REG_GLYPHS_PER_ROW = 3'd2,
		REG_ATLAS_BASE_U   = 3'd3,
		REG_ATLAS_BASE_V   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_RED   = 2'd1,
		ESC_GREEN = 2'd2,
		ESC_BLUE  = 2'd3
	} esc_phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_MUL
	} back_state_t;

	typedef struct packed {
		logic [7:0] glyph_width;
		logic [7:0] glyph_height;
		logic [7:0] glyphs_per_row;
		logic [7:0] atlas_base_u;
		logic [7:0] atlas_base_v;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  text_byte;
		logic        string_start;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
	} in_item_t;

	typedef struct packed {
		logic [15:0] draw_x;
		logic [15:0] draw_y;
		logic [7:0]  tex_u;
		logic [7:0]  tex_v;
		logic [7:0]  color_red;
		logic [7:0]  color_green;
		logic [7:0]  color_blue;
	} out_item_t;

	// One glyph to draw, fully placed on screen; only the atlas cell is left to work out
	typedef struct packed {
		logic [15:0]      draw_x;
		logic [15:0]      draw_y;
		logic [IDX_W-1:0] glyph_idx;
		logic [7:0]       color_red;
		logic [7:0]       color_green;
		logic [7:0]       color_blue;
	} glyph_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef struct packed {
		logic busy;
		logic dividing;
	} back_status_t;

endpackage

`default_nettype wire

FILE: rtl/bfl_front.sv
// Front end: accepts text bytes, keeps cursor, colour, escape and length state.
// Pushes one glyph command per printable byte into the queue. Uses bfl_pkg.
`default_nettype none

module bfl_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  bfl_pkg::in_item_t     in_item,
	input  bfl_pkg::cfg_t         cfg,
	input  bfl_pkg::fifo_status_t fifo_st,
	output logic                  push,
	output bfl_pkg::glyph_cmd_t   push_cmd
);
	import bfl_pkg::*;

	logic [15:0]      cursor_x_q, cursor_y_q, line_x_q;
	logic [7:0]       red_q, green_q, blue_q;
	esc_phase_t       esc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ended_q;

	logic [15:0]      cx, cy, lx;
	logic [7:0]       r, g, b;
	esc_phase_t       esc;
	logic [CNT_W-1:0] cnt;
	logic             ended;
	logic             glyph;
	logic [7:0]       tb;
	logic [7:0]       idx_full;
	logic             accept;

	assign in_ready = !fifo_st.full;
	assign accept   = in_valid && in_ready;
	assign tb       = in_item.text_byte;
	assign idx_full = tb - GLYPH_OFFSET;

	always_comb begin
		cx    = cursor_x_q;
		cy    = cursor_y_q;
		lx    = line_x_q;
		r     = red_q;
		g     = green_q;
		b     = blue_q;
		esc   = esc_q;
		cnt   = cnt_q;
		ended = ended_q;
		glyph = 1'b0;

		if (in_item.string_start) begin
			cx    = in_item.origin_x;
			lx    = in_item.origin_x;
			cy    = in_item.origin_y;
			r     = RESET_GRAY;
			g     = RESET_GRAY;
			b     = RESET_GRAY;
			esc   = ESC_NONE;
			cnt   = '0;
			ended = 1'b0;
		end

		push_cmd.draw_x      = cx;
		push_cmd.draw_y      = cy + DRAW_Y_OFFSET;
		push_cmd.glyph_idx   = idx_full[IDX_W-1:0];
		push_cmd.color_red   = r;
		push_cmd.color_green = g;
		push_cmd.color_blue  = b;

		if (!ended) begin
			if (cnt < CNT_W'(MAX_STRING_BYTES))
				cnt = cnt + 1'b1;

			if (esc != ESC_NONE) begin
				unique case (esc)
					ESC_RED: begin
						r   = tb;
						esc = ESC_GREEN;
					end
					ESC_GREEN: begin
						g   = tb;
						esc = ESC_BLUE;
					end
					default: begin
						b   = tb;
						esc = ESC_NONE;
					end
				endcase
				if (esc == ESC_NONE && cnt >= CNT_W'(MAX_STRING_BYTES))
					ended = 1'b1;
			end else if (tb == NUL_BYTE) begin
				ended = 1'b1;
			end else begin
				priority if (tb >= HIGH_FIRST) begin
					if (tb == ESC_BYTE)
						esc = ESC_RED;
				end else if (tb == NL_BYTE) begin
					cx = lx;
					cy = cy + 16'(cfg.glyph_height);
				end else if (tb == SPACE_BYTE) begin
					cx = cx + 16'(cfg.glyph_width);
				end else if (tb >= GLYPH_FIRST) begin
					glyph = 1'b1;
					cx    = cx + 16'(cfg.glyph_width);
				end else begin
					// other control bytes: skip
				end
				if (esc == ESC_NONE && cnt >= CNT_W'(MAX_STRING_BYTES))
					ended = 1'b1;
			end
		end
	end

	assign push = accept && glyph;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			line_x_q   <= '0;
			red_q      <= RESET_GRAY;
			green_q    <= RESET_GRAY;
			blue_q     <= RESET_GRAY;
			esc_q      <= ESC_NONE;
			cnt_q      <= '0;
			ended_q    <= 1'b1;
		end else if (accept) begin
			cursor_x_q <= cx;
			cursor_y_q <= cy;
			line_x_q   <= lx;
			red_q      <= r;
			green_q    <= g;
			blue_q     <= b;
			esc_q      <= esc;
			cnt_q      <= cnt;
			ended_q    <= ended;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bfl_fifo.sv
// Short glyph command queue between front and back end.
// Uses bfl_pkg for the command type and depth.
`default_nettype none

module bfl_fifo (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  bfl_pkg::glyph_cmd_t   push_cmd,
	input  wire                   pop,
	output bfl_pkg::glyph_cmd_t   pop_cmd,
	output bfl_pkg::fifo_status_t status
);
	import bfl_pkg::*;

	glyph_cmd_t         entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign status.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_cmd      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bfl_back.sv
// Back end: splits the atlas index by a bit-serial divider, scales the cell
// position and holds the finished draw command in an output register. Uses bfl_pkg.
`default_nettype none

module bfl_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  bfl_pkg::cfg_t         cfg,
	input  bfl_pkg::fifo_status_t fifo_st,
	output logic                  pop,
	input  bfl_pkg::glyph_cmd_t   pop_cmd,
	output logic                  out_valid,
	input  wire                   out_ready,
	output bfl_pkg::out_item_t    out_item,
	output bfl_pkg::back_status_t status
);
	import bfl_pkg::*;

	localparam int unsigned STEP_W = $clog2(IDX_W);

	back_state_t       state_q, state_d;
	glyph_cmd_t        cmd_q;
	logic [IDX_W-1:0]  quo_q;
	logic [7:0]        rem_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [8:0]       divisor;
	logic [8:0]       trial;
	logic             fits;
	logic [15:0]      u_prod, v_prod;
	logic             load_out;

	// Zero cells per row reads as 256: nothing ever fits, column is the index
	assign divisor = {cfg.glyphs_per_row == 8'd0, cfg.glyphs_per_row};
	assign trial   = {rem_q, quo_q[IDX_W-1]};
	assign fits    = trial >= divisor;

	assign u_prod = cfg.glyph_width * rem_q;
	assign v_prod = cfg.glyph_height * 8'(quo_q);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!fifo_st.empty) begin
					pop     = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == STEP_W'(IDX_W - 1))
					state_d = BK_MUL;
			end
			BK_MUL: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop)
				step_q <= '0;
			else if (state_q == BK_DIV)
				step_q <= step_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_cmd;
			quo_q <= pop_cmd.glyph_idx;
			rem_q <= '0;
		end else if (state_q == BK_DIV) begin
			quo_q <= {quo_q[IDX_W-2:0], fits};
			rem_q <= fits ? 8'(trial - divisor) : trial[7:0];
		end
		if (load_out) begin
			out_q.draw_x      <= cmd_q.draw_x;
			out_q.draw_y      <= cmd_q.draw_y;
			out_q.tex_u       <= u_prod[7:0] + cfg.atlas_base_u;
			out_q.tex_v       <= v_prod[7:0] + cfg.atlas_base_v;
			out_q.color_red   <= cmd_q.color_red;
			out_q.color_green <= cmd_q.color_green;
			out_q.color_blue  <= cmd_q.color_blue;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_item        = out_q;
	assign status.busy     = (state_q != BK_IDLE);
	assign status.dividing = (state_q == BK_DIV);

endmodule

`default_nettype wire

FILE: rtl/bitmap_font_text_layout.sv
// Bitmap font text layout: one text byte in per transaction, one glyph draw out per printable byte.
// A glyph byte accepted with queue and back end idle is queued, popped, divided and scaled before out_valid rises.
// Throughput: one byte per cycle in while the queue has room; the back end takes one glyph at a time
// (pop, 7 divider steps, scale), so a run of glyphs fills the queue and stalls the byte stream.
// Reset: arst_n clears cursor, colour (128 grey), queue and output; the block waits for a start.
// Configuration registers reset to 8, 8, 16, 0, 0. Depends on bfl_pkg, bfl_front, bfl_fifo, bfl_back.
`default_nettype none

module bitmap_font_text_layout (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  bfl_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  wire                out_ready,
	output bfl_pkg::out_item_t out_item,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [2:0]          cfg_index,
	input  wire [7:0]          cfg_data
);
	import bfl_pkg::*;

	cfg_t         cfg_q;
	fifo_status_t fifo_st;
	back_status_t back_st;
	logic         push, pop;
	glyph_cmd_t   push_cmd, pop_cmd;

	// Register writes are always taken and land at once; write them only with nothing in flight
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_width    <= RST_GLYPH_WIDTH;
			cfg_q.glyph_height   <= RST_GLYPH_HEIGHT;
			cfg_q.glyphs_per_row <= RST_GLYPHS_PER_ROW;
			cfg_q.atlas_base_u   <= RST_ATLAS_BASE_U;
			cfg_q.atlas_base_v   <= RST_ATLAS_BASE_V;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GLYPH_WIDTH:    cfg_q.glyph_width    <= cfg_data;
				REG_GLYPH_HEIGHT:   cfg_q.glyph_height   <= cfg_data;
				REG_GLYPHS_PER_ROW: cfg_q.glyphs_per_row <= cfg_data;
				REG_ATLAS_BASE_U:   cfg_q.atlas_base_u   <= cfg_data;
				REG_ATLAS_BASE_V:   cfg_q.atlas_base_v   <= cfg_data;
				default: ; // unknown index: drop the write
			endcase
		end
	end

	// Front: classify each byte, advance cursor and colour, queue glyphs
	bfl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.fifo_st  (fifo_st),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Queue: decouples the byte stream from the slower atlas lookup
	bfl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.status   (fifo_st)
	);

	// Back: divide the atlas index into row and column, scale, hold the result
	bfl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fifo_st   (fifo_st),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.status    (back_st)
	);

	// Stall the byte stream whenever the queue has no room
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_st.full |-> !in_ready)
		else $error("byte accepted with glyph queue full");

	// A waiting command is picked up by an idle back end at once
	a_back_picks_up: assert property (@(posedge clk) disable iff (!arst_n)
		(!fifo_st.empty && !back_st.busy) |=> back_st.dividing)
		else $error("back end left a queued glyph waiting");

	// A new result only comes out of a working back end
	a_out_from_back: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(back_st.busy))
		else $error("result appeared without back end activity");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_st.empty)
		else $error("glyph queue popped while empty");

endmodule

`default_nettype wire
